[rtl/chs_lba_pkg.sv]
// types and constants shared by the chs/lba translator core and its checker
// no dependencies
package chs_lba_pkg;

   localparam int CYL_W       = 14;
   localparam int HEAD_W      = 4;
   localparam int SECT_W      = 8;
   localparam int LBA_FIELD_W = 48;
   localparam int HEADS_W     = 5;
   localparam int GEOM_W      = SECT_W + HEAD_W;     // spt * heads, at most 4080
   localparam int CH_W        = CYL_W + HEAD_W;      // cyl * heads + head
   localparam int LBA_CORE_W  = GEOM_W + CYL_W;      // every lba inside the chs reach

   localparam logic [CYL_W-1:0]   CYL_MAX     = 14'd16383;
   localparam logic [HEAD_W-1:0]  HEAD_MAX    = 4'd15;
   localparam logic [SECT_W-1:0]  SECTOR_MAX  = 8'd255;
   localparam logic [HEADS_W-1:0] HEADS_MAX   = 5'd16;
   localparam logic [SECT_W-1:0]  SPT_RESET   = 8'd63;
   localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SECTORS_PER_TRACK = 2'd0,
      CSR_HEAD_COUNT        = 2'd1
   } csr_index_type;

   // divider pipeline shape: quotient bits resolved per stage
   localparam int CYL_STEPS   = 3;
   localparam int HEAD_STEPS  = 2;
   localparam int CYL_STAGES  = (CYL_W + CYL_STEPS - 1) / CYL_STEPS;
   localparam int HEAD_STAGES = (HEAD_W + HEAD_STEPS - 1) / HEAD_STEPS;
   // accept edge to the edge at which the result is taken
   localparam int PIPE_LATENCY = 3 + CYL_STAGES + HEAD_STAGES;

   typedef struct packed {
      logic                   mode;
      logic [15:0]            cylinder_in;
      logic [7:0]             head_in;
      logic [7:0]             sector_in;
      logic [LBA_FIELD_W-1:0] block_address_in;
   } req_type;

   typedef struct packed {
      logic [CYL_W-1:0]       cylinder_out;
      logic [HEAD_W-1:0]      head_out;
      logic [SECT_W-1:0]      sector_out;
      logic [LBA_FIELD_W-1:0] block_address_out;
      logic                   saturated;
   } rsp_type;

endpackage

[rtl/chs_lba_translator_core.sv]
// chs <-> lba translator: one item per cycle while busy is low (a start while busy is dropped);
// results appear in order, and the receiver cannot hold them off.
// Each result passes through the cylinder divider (lba / (spt*heads), five stages of three
// quotient bits, two in the last) followed by the head divider (remainder / spt, two
// stages), plus input, geometry and output registers. csr_ready is high only while nothing
// is in flight, and busy is high only in a cycle in which a csr write is accepted.
// depends on chs_lba_pkg and chs_lba_div
module chs_lba_translator_core #(
   parameter int LBA_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  chs_lba_pkg::req_type                 req_item,
   output logic                                 rsp_strobe,
   output chs_lba_pkg::rsp_type                 rsp_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [chs_lba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [chs_lba_pkg::CSR_DATA_W-1:0]   csr_data
);
   import chs_lba_pkg::*;

   localparam int LBA_W    = (LBA_BITS < LBA_FIELD_W) ? LBA_BITS : LBA_FIELD_W;
   localparam int SIDE_LEN = CYL_STAGES + HEAD_STAGES;

   typedef struct packed {
      logic               mode;
      logic [CYL_W-1:0]   cyl;
      logic [HEAD_W-1:0]  head;
      logic [SECT_W-1:0]  sect;
      logic [LBA_W-1:0]   lba;
      logic [SECT_W-1:0]  spt;
      logic [HEADS_W-1:0] heads;
   } s1_type;

   typedef struct packed {
      logic               mode;
      logic [CYL_W-1:0]   cyl;
      logic [HEAD_W-1:0]  head;
      logic [SECT_W-1:0]  sect;
      logic [LBA_W-1:0]   lba;
      logic [SECT_W-1:0]  spt;
      logic [HEADS_W-1:0] heads;
      logic [CH_W-1:0]    ch;
      logic [GEOM_W-1:0]  geom;
   } s2_type;

   typedef struct packed {
      logic                   mode;
      logic                   sat;
      logic [LBA_FIELD_W-1:0] lba_out;
      logic [CYL_W-1:0]       cyl;
      logic [HEAD_W-1:0]      head;
      logic [SECT_W-1:0]      sect;
      logic [SECT_W-1:0]      spt;
      logic [HEAD_W-1:0]      head_last;
   } side_type;

   logic [SECT_W-1:0]   spt_ff;
   logic [HEADS_W-1:0]  heads_ff;

   s1_type              s1_in, s1_ff;
   logic                s1_valid_ff;
   s2_type              s2_in, s2_ff;
   logic                s2_valid_ff;
   side_type            side_in;
   side_type            side_ff [SIDE_LEN];
   logic [SIDE_LEN-1:0] side_valid_ff;
   logic [CYL_W-1:0]    cylq_ff [HEAD_STAGES];
   rsp_type             rsp_in, rsp_ff;
   logic                rsp_strobe_ff;

   logic [CYL_W-1:0]    cyl_quo;
   logic [GEOM_W-1:0]   cyl_rem;
   logic [HEAD_W-1:0]   head_quo;
   logic [SECT_W-1:0]   head_rem;
   logic [CH_W-1:0]     ch_head;
   logic [LBA_CORE_W-1:0] lba_chs;
   side_type            tail;

   assign csr_ready = ~(s1_valid_ff | s2_valid_ff | (|side_valid_ff) | rsp_strobe_ff);
   assign busy      = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= SPT_RESET;
         heads_ff <= HEADS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SECTORS_PER_TRACK: spt_ff   <= csr_data[SECT_W-1:0];
            CSR_HEAD_COUNT:        heads_ff <= csr_data[HEADS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the chs fields and fix up the geometry
   always_comb begin
      s1_in.mode  = req_item.mode;
      s1_in.cyl   = (req_item.cylinder_in > 16'(CYL_MAX)) ? CYL_MAX
                                                          : req_item.cylinder_in[CYL_W-1:0];
      s1_in.head  = (req_item.head_in > 8'(HEAD_MAX)) ? HEAD_MAX
                                                      : req_item.head_in[HEAD_W-1:0];
      s1_in.sect  = (req_item.sector_in == '0) ? SECT_W'(1) : req_item.sector_in;
      s1_in.lba   = req_item.block_address_in[LBA_W-1:0];
      s1_in.spt   = (spt_ff == '0) ? SECT_W'(1) : spt_ff;
      if (heads_ff == '0) begin
         s1_in.heads = HEADS_W'(1);
      end else if (heads_ff > HEADS_MAX) begin
         s1_in.heads = HEADS_MAX;
      end else begin
         s1_in.heads = heads_ff;
      end
   end

   // geometry product and cylinder-times-heads
   always_comb begin
      s2_in.mode  = s1_ff.mode;
      s2_in.cyl   = s1_ff.cyl;
      s2_in.head  = s1_ff.head;
      s2_in.sect  = s1_ff.sect;
      s2_in.lba   = s1_ff.lba;
      s2_in.spt   = s1_ff.spt;
      s2_in.heads = s1_ff.heads;
      s2_in.ch    = CH_W'(s1_ff.cyl) * CH_W'(s1_ff.heads) + CH_W'(s1_ff.head);
      s2_in.geom  = GEOM_W'(s1_ff.spt) * GEOM_W'(s1_ff.heads);
   end

   // chs to lba, and the reach check for lba to chs
   assign ch_head = s2_ff.ch;
   assign lba_chs = LBA_CORE_W'(ch_head) * LBA_CORE_W'(s2_ff.spt)
                  + LBA_CORE_W'(s2_ff.sect - SECT_W'(1));

   always_comb begin
      side_in.mode      = s2_ff.mode;
      side_in.sat       = s2_ff.mode & (s2_ff.lba >= LBA_W'({s2_ff.geom, {CYL_W{1'b0}}}));
      side_in.lba_out   = s2_ff.mode ? LBA_FIELD_W'(s2_ff.lba) : LBA_FIELD_W'(lba_chs);
      side_in.cyl       = s2_ff.cyl;
      side_in.head      = s2_ff.head;
      side_in.sect      = s2_ff.sect;
      side_in.spt       = s2_ff.spt;
      side_in.head_last = HEAD_W'(s2_ff.heads - HEADS_W'(1));
   end

   // cylinder = lba / (spt*heads), the remainder then splits into head and sector
   chs_lba_div #(
      .Q_W   (CYL_W),
      .D_W   (GEOM_W),
      .STEPS (CYL_STEPS)
   ) u_cyl_div (
      .clock     (clock),
      .dividend  (s2_ff.lba[LBA_CORE_W-1:0]),
      .divisor   (s2_ff.geom),
      .quotient  (cyl_quo),
      .remainder (cyl_rem)
   );

   chs_lba_div #(
      .Q_W   (HEAD_W),
      .D_W   (SECT_W),
      .STEPS (HEAD_STEPS)
   ) u_head_div (
      .clock     (clock),
      .dividend  (cyl_rem),
      .divisor   (side_ff[CYL_STAGES-1].spt),
      .quotient  (head_quo),
      .remainder (head_rem)
   );

   assign tail = side_ff[SIDE_LEN-1];

   always_comb begin
      rsp_in.block_address_out = tail.lba_out;
      if (!tail.mode) begin
         rsp_in.cylinder_out = tail.cyl;
         rsp_in.head_out     = tail.head;
         rsp_in.sector_out   = tail.sect;
         rsp_in.saturated    = 1'b0;
      end else if (tail.sat) begin
         rsp_in.cylinder_out = CYL_MAX;
         rsp_in.head_out     = tail.head_last;
         rsp_in.sector_out   = tail.spt;
         rsp_in.saturated    = 1'b1;
      end else begin
         rsp_in.cylinder_out = cylq_ff[HEAD_STAGES-1];
         rsp_in.head_out     = head_quo;
         rsp_in.sector_out   = head_rem + SECT_W'(1);
         rsp_in.saturated    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         side_valid_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= start & ~busy;
         s2_valid_ff   <= s1_valid_ff;
         side_valid_ff <= {side_valid_ff[SIDE_LEN-2:0], s2_valid_ff};
         rsp_strobe_ff <= side_valid_ff[SIDE_LEN-1];
      end
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      side_ff[0] <= side_in;
      for (int i = 1; i < SIDE_LEN; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      // cylinder quotient waits for the head divider
      cylq_ff[0] <= cyl_quo;
      for (int i = 1; i < HEAD_STAGES; i++) begin
         cylq_ff[i] <= cylq_ff[i-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/chs_lba_div.sv]
// pipelined restoring divider for a quotient of known width
// dividend must stay below divisor << Q_W; uses no package
module chs_lba_div #(
   parameter int Q_W   = 14,
   parameter int D_W   = 12,
   parameter int STEPS = 3
) (
   input  logic             clock,
   input  logic [D_W+Q_W-1:0] dividend,
   input  logic [D_W-1:0]   divisor,
   output logic [Q_W-1:0]   quotient,
   output logic [D_W-1:0]   remainder
);
   localparam int STAGES = (Q_W + STEPS - 1) / STEPS;

   logic [D_W-1:0] rem_ff  [STAGES];
   logic [Q_W-1:0] word_ff [STAGES];
   logic [D_W-1:0] div_ff  [STAGES];

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_stage
         localparam int NSTEP = (Q_W - s * STEPS < STEPS) ? Q_W - s * STEPS : STEPS;

         logic [D_W-1:0] rem_src;
         logic [Q_W-1:0] word_src;
         logic [D_W-1:0] div_src;
         logic [D_W-1:0] rem_in;
         logic [Q_W-1:0] word_in;

         if (s == 0) begin : g_first
            assign rem_src  = dividend[D_W+Q_W-1:Q_W];
            assign word_src = dividend[Q_W-1:0];
            assign div_src  = divisor;
         end else begin : g_next
            assign rem_src  = rem_ff[s-1];
            assign word_src = word_ff[s-1];
            assign div_src  = div_ff[s-1];
         end

         // dividend bits shift out at the top, quotient bits shift in at the bottom
         always_comb begin
            logic [D_W:0] trial;
            rem_in  = rem_src;
            word_in = word_src;
            trial   = '0;
            for (int k = 0; k < NSTEP; k++) begin
               trial = {rem_in, word_in[Q_W-1]};
               if (trial >= {1'b0, div_src}) begin
                  rem_in  = D_W'(trial - {1'b0, div_src});
                  word_in = {word_in[Q_W-2:0], 1'b1};
               end else begin
                  rem_in  = trial[D_W-1:0];
                  word_in = {word_in[Q_W-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[s]  <= rem_in;
            word_ff[s] <= word_in;
            div_ff[s]  <= div_src;
         end
      end
   endgenerate

   assign quotient  = word_ff[STAGES-1];
   assign remainder = rem_ff[STAGES-1];

endmodule

[rtl/chs_lba_checker.sv]
// port-level checks for the chs/lba translator core, bound to the translator core
// depends on chs_lba_pkg
module chs_lba_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input chs_lba_pkg::rsp_type rsp_item
);
   import chs_lba_pkg::*;

   // every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##PIPE_LATENCY rsp_strobe)
      else $error("item accepted but no result after the pipeline latency");

   // no result without an item accepted one latency earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching accepted item");

   a_sector_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.sector_out != '0)
      else $error("sector of a result is zero");

   a_saturated_last_cyl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.saturated |-> rsp_item.cylinder_out == CYL_MAX)
      else $error("saturated result not on the last cylinder");

endmodule

bind chs_lba_translator_core chs_lba_checker u_checker (.*);
